@@ hdl/bcs_pkg.sv @@
package bcs_pkg;

    localparam int PENDING_DEPTH_DEF = 8;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TONE_HZ      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_TICKS   = 3'd4;

    localparam logic [15:0] RST_TONE_HZ     = 16'd2000;
    localparam logic [15:0] RST_BEEP_TICKS  = 16'd300;
    localparam logic [15:0] RST_GAP_TICKS   = 16'd300;
    localparam logic [15:0] RST_DIGIT_TICKS = 16'd800;
    localparam logic [15:0] RST_POST_TICKS  = 16'd1000;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_REQ  = 1'b1;

    localparam logic [3:0] IDX_MIN = 4'd1;
    localparam logic [3:0] IDX_MAX = 4'd9;

    typedef enum logic [2:0] {
        ST_TICK    = 3'd0,
        ST_STARTED = 3'd1,
        ST_QUEUED  = 3'd2,
        ST_INVALID = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [3:0] idx;
    } q_ctrl_t;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [3:0] head;
    } q_stat_t;

    function automatic logic [15:0] pattern_rom(input logic [3:0] idx);
        logic [15:0] p;
        unique case (idx)
            4'd1:    p = 16'h1512;
            4'd2:    p = 16'h1514;
            4'd3:    p = 16'h1521;
            4'd4:    p = 16'h1522;
            4'd5:    p = 16'h1523;
            4'd6:    p = 16'h1524;
            4'd7:    p = 16'h1525;
            4'd8:    p = 16'h1542;
            4'd9:    p = 16'h1544;
            default: p = 16'h0000;
        endcase
        return p;
    endfunction

endpackage

@@ hdl/bcs_req_if.sv @@
interface bcs_req_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [3:0] code_index;

    modport source (output valid, output cmd, output code_index, input ready);
    modport sink (input valid, input cmd, input code_index, output ready);
endinterface

@@ hdl/bcs_rsp_if.sv @@
interface bcs_rsp_if;
    logic        valid;
    logic        ready;
    logic        tone_on;
    logic [15:0] tone_freq;
    logic        busy_res;
    logic [2:0]  status;
    logic [3:0]  playing_index;

    modport source (output valid, output tone_on, output tone_freq, output busy_res,
                    output status, output playing_index, input ready);
    modport sink (input valid, input tone_on, input tone_freq, input busy_res,
                  input status, input playing_index, output ready);
endinterface

@@ hdl/bcs_cfg_if.sv @@
interface bcs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bcs_pkg::CFG_IDX_W-1:0] index;
    logic [15:0]                   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/bcs_cell.sv @@
module bcs_cell (
    input  logic             clk,
    input  bcs_pkg::q_ctrl_t ctrl,
    input  logic             here_valid,
    input  logic             prev_valid,
    input  logic             prev_ge,
    input  logic [3:0]       prev_data,
    input  logic [3:0]       next_data,
    output logic [3:0]       data,
    output logic             ge
);

    logic [3:0] data_reg;
    logic [3:0] data_next;

    assign data = data_reg;
    assign ge   = here_valid && (data_reg >= ctrl.idx);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.pop)
        begin
            data_next = next_data;
        end
        else if (ctrl.push && !ge)
        begin
            if (prev_ge)
            begin
                data_next = ctrl.idx;
            end
            else if (prev_valid)
            begin
                data_next = prev_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

@@ hdl/bcs_queue.sv @@
module bcs_queue #(
    parameter int PENDING_DEPTH = bcs_pkg::PENDING_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bcs_pkg::q_ctrl_t ctrl,
    output bcs_pkg::q_stat_t stat
);

    localparam int CW = $clog2(PENDING_DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [3:0]    data [PENDING_DEPTH];
    logic          ge   [PENDING_DEPTH];
    logic          vld  [PENDING_DEPTH];

    genvar i;
    generate
        for (i = 0; i < PENDING_DEPTH; i++)
        begin : g_cell
            logic       p_valid;
            logic       p_ge;
            logic [3:0] p_data;
            logic [3:0] n_data;

            assign vld[i] = count_reg > CW'(i);

            if (i == 0)
            begin : g_first
                assign p_valid = 1'b1;
                assign p_ge    = 1'b1;
                assign p_data  = ctrl.idx;
            end
            else
            begin : g_mid
                assign p_valid = vld[i-1];
                assign p_ge    = ge[i-1];
                assign p_data  = data[i-1];
            end

            if (i == PENDING_DEPTH - 1)
            begin : g_last
                assign n_data = data[i];
            end
            else
            begin : g_inner
                assign n_data = data[i+1];
            end

            bcs_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .here_valid (vld[i]),
                .prev_valid (p_valid),
                .prev_ge    (p_ge),
                .prev_data  (p_data),
                .next_data  (n_data),
                .data       (data[i]),
                .ge         (ge[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.pop && count_reg != '0)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (ctrl.push && count_reg != CW'(PENDING_DEPTH))
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign stat.full  = count_reg == CW'(PENDING_DEPTH);
    assign stat.empty = count_reg == '0;
    assign stat.head  = data[0];

endmodule

@@ hdl/beep_code_sequencer.sv @@
// Beep code sequencer.
// req channel: one word per event, cmd 0 is a timer tick, cmd 1 a beep
// request with code_index 1..9 (other indexes are answered as invalid).
// rsp channel: exactly one word per accepted req word, showing the tone
// state after that event plus a status code (tick, started, queued,
// invalid, queue full).
// cfg channel: register writes (tone_hz, beep_ticks, gap_ticks,
// digit_gap_ticks, post_ticks); always ready, a write applies to req words
// accepted after it.
// A req word is handled in the cycle it is accepted and its rsp word
// appears in the next cycle from the output register.
// Throughput: one word per cycle while rsp is taken; req stays accepted
// while the output register is empty or being read in the same cycle.
// Pending requests sit in a row of cells sorted largest index first; a
// pop moves every cell by one place, an insert only those behind it.
// Reset: tone off, idle, queue empty, registers at their defaults.
// If the receiver stalls, the rsp word holds and req ready drops.
module beep_code_sequencer #(
    parameter int PENDING_DEPTH = bcs_pkg::PENDING_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bcs_req_if.sink    req,
    bcs_rsp_if.source  rsp,
    bcs_cfg_if.sink    cfg
);

    typedef enum logic [4:0] {
        PH_OFF    = 5'b00001,
        PH_ON     = 5'b00010,
        PH_IBEEP  = 5'b00100,
        PH_IDIGIT = 5'b01000,
        PH_POST   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [3:0]  nib;
        logic [15:0] code;
        logic [2:0]  pos;
    } digit_t;

    function automatic digit_t next_digit(input logic [15:0] code, input logic [2:0] pos);
        digit_t d;
        logic   found;
        d.nib  = 4'd0;
        d.code = code;
        d.pos  = pos;
        found  = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (!found && d.pos != 3'd0)
            begin
                d.nib = d.code[4*(d.pos-3'd1) +: 4];
                d.code[4*(d.pos-3'd1) +: 4] = 4'd0;
                d.pos = d.pos - 3'd1;
                found = d.nib != 4'd0;
            end
        end
        return d;
    endfunction

    logic [15:0] tone_hz_reg, beep_ticks_reg, gap_ticks_reg, digit_ticks_reg, post_ticks_reg;

    logic        running_reg, running_next;
    phase_t      phase_reg, phase_next;
    logic [15:0] code_left_reg, code_left_next;
    logic [3:0]  beeps_left_reg, beeps_left_next;
    logic [2:0]  nibble_pos_reg, nibble_pos_next;
    logic [15:0] delay_left_reg, delay_left_next;
    logic [3:0]  current_index_reg, current_index_next;

    logic        out_valid_reg;
    logic        tone_on_reg;
    logic        busy_reg;
    logic [2:0]  status_reg;
    logic [3:0]  playing_reg;
    logic [15:0] freq_reg;

    bcs_pkg::q_ctrl_t q_ctrl;
    bcs_pkg::q_stat_t q_stat;
    bcs_pkg::status_t status;

    logic   accept;
    logic   do_start;
    logic   do_load;
    logic [3:0] start_idx;
    digit_t dig;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    bcs_queue #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (q_ctrl),
        .stat  (q_stat)
    );

    always_comb
    begin
        running_next       = running_reg;
        phase_next         = phase_reg;
        code_left_next     = code_left_reg;
        beeps_left_next    = beeps_left_reg;
        nibble_pos_next    = nibble_pos_reg;
        delay_left_next    = delay_left_reg;
        current_index_next = current_index_reg;
        status             = bcs_pkg::ST_TICK;
        q_ctrl             = '0;
        q_ctrl.idx         = req.code_index;
        do_start           = 1'b0;
        do_load            = 1'b0;
        start_idx          = req.code_index;

        if (accept)
        begin
            if (req.cmd == bcs_pkg::CMD_TICK)
            begin
                if (running_reg)
                begin
                    if (delay_left_reg > 16'd1)
                    begin
                        delay_left_next = delay_left_reg - 16'd1;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_ON:
                            begin
                                if (beeps_left_reg == 4'd0)
                                begin
                                    if (code_left_reg == 16'd0)
                                    begin
                                        phase_next      = PH_POST;
                                        delay_left_next = post_ticks_reg;
                                    end
                                    else
                                    begin
                                        do_load         = 1'b1;
                                        phase_next      = PH_IDIGIT;
                                        delay_left_next = digit_ticks_reg;
                                    end
                                end
                                else
                                begin
                                    beeps_left_next = beeps_left_reg - 4'd1;
                                    phase_next      = PH_IBEEP;
                                    delay_left_next = gap_ticks_reg;
                                end
                            end
                            PH_IBEEP, PH_IDIGIT:
                            begin
                                phase_next      = PH_ON;
                                delay_left_next = beep_ticks_reg;
                            end
                            PH_POST:
                            begin
                                if (!q_stat.empty)
                                begin
                                    q_ctrl.pop = 1'b1;
                                    do_start   = 1'b1;
                                    start_idx  = (q_stat.head <= bcs_pkg::IDX_MAX) ?
                                                 q_stat.head : 4'd0;
                                end
                                else
                                begin
                                    running_next       = 1'b0;
                                    phase_next         = PH_OFF;
                                    current_index_next = 4'd0;
                                    delay_left_next    = 16'd0;
                                end
                            end
                            default:
                            begin
                                running_next       = 1'b0;
                                phase_next         = PH_OFF;
                                current_index_next = 4'd0;
                                delay_left_next    = 16'd0;
                            end
                        endcase
                    end
                end
            end
            else if (req.code_index < bcs_pkg::IDX_MIN || req.code_index > bcs_pkg::IDX_MAX)
            begin
                status = bcs_pkg::ST_INVALID;
            end
            else if (running_reg)
            begin
                if (q_stat.full)
                begin
                    status = bcs_pkg::ST_FULL;
                end
                else
                begin
                    q_ctrl.push = 1'b1;
                    status      = bcs_pkg::ST_QUEUED;
                end
            end
            else
            begin
                do_start = 1'b1;
                status   = bcs_pkg::ST_STARTED;
            end
        end

        if (do_start)
        begin
            dig                = next_digit(bcs_pkg::pattern_rom(start_idx), 3'd4);
            current_index_next = start_idx;
            phase_next         = PH_ON;
            running_next       = 1'b1;
            delay_left_next    = beep_ticks_reg;
        end
        else
        begin
            dig = next_digit(code_left_reg, nibble_pos_reg);
        end

        if (do_start || do_load)
        begin
            code_left_next  = dig.code;
            nibble_pos_next = dig.pos;
            beeps_left_next = (dig.nib != 4'd0) ? dig.nib - 4'd1 : 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg       <= 1'b0;
            phase_reg         <= PH_OFF;
            code_left_reg     <= 16'd0;
            beeps_left_reg    <= 4'd0;
            nibble_pos_reg    <= 3'd0;
            delay_left_reg    <= 16'd0;
            current_index_reg <= 4'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            running_reg       <= running_next;
            phase_reg         <= phase_next;
            code_left_reg     <= code_left_next;
            beeps_left_reg    <= beeps_left_next;
            nibble_pos_reg    <= nibble_pos_next;
            delay_left_reg    <= delay_left_next;
            current_index_reg <= current_index_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_hz_reg     <= bcs_pkg::RST_TONE_HZ;
            beep_ticks_reg  <= bcs_pkg::RST_BEEP_TICKS;
            gap_ticks_reg   <= bcs_pkg::RST_GAP_TICKS;
            digit_ticks_reg <= bcs_pkg::RST_DIGIT_TICKS;
            post_ticks_reg  <= bcs_pkg::RST_POST_TICKS;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                bcs_pkg::CFG_TONE_HZ:     tone_hz_reg     <= cfg.data;
                bcs_pkg::CFG_BEEP_TICKS:  beep_ticks_reg  <= cfg.data;
                bcs_pkg::CFG_GAP_TICKS:   gap_ticks_reg   <= cfg.data;
                bcs_pkg::CFG_DIGIT_TICKS: digit_ticks_reg <= cfg.data;
                bcs_pkg::CFG_POST_TICKS:  post_ticks_reg  <= cfg.data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tone_on_reg <= running_next && (phase_next == PH_ON);
            busy_reg    <= running_next;
            status_reg  <= status;
            playing_reg <= running_next ? current_index_next : 4'd0;
            freq_reg    <= tone_hz_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.tone_on       = tone_on_reg;
    assign rsp.tone_freq     = freq_reg;
    assign rsp.busy_res      = busy_reg;
    assign rsp.status        = status_reg;
    assign rsp.playing_index = playing_reg;

endmodule

@@ tb/beep_code_sequencer_test.sv @@
typedef enum logic [2:0] {
    SEQ_IDLE      = 3'd0,
    SEQ_TONE      = 3'd1,
    SEQ_BEEP_GAP  = 3'd2,
    SEQ_DIGIT_GAP = 3'd3,
    SEQ_TAIL      = 3'd4
} seq_stage_t;

typedef struct packed {
    logic             tone_on;
    logic [15:0]      freq;
    logic             busy;
    bcs_pkg::status_t status;
    logic [3:0]       playing;
} tone_word_t;

class tone_scoreboard;
    logic [15:0] cfg_tone;
    logic [15:0] cfg_beep;
    logic [15:0] cfg_gap;
    logic [15:0] cfg_digit;
    logic [15:0] cfg_post;

    bit          active;
    seq_stage_t  stage;
    logic [15:0] nibbles_rest;
    logic [3:0]  beeps_rest;
    int          nibble_cnt;
    logic [15:0] ticks_rest;
    logic [3:0]  waitq[$];
    logic [3:0]  cur_code;

    tone_word_t  expected_words[$];

    int n_checked;
    int n_errors;
    int n_started;
    int n_queued;
    int n_full;
    int n_invalid;

    function new();
        cfg_tone     = bcs_pkg::RST_TONE_HZ;
        cfg_beep     = bcs_pkg::RST_BEEP_TICKS;
        cfg_gap      = bcs_pkg::RST_GAP_TICKS;
        cfg_digit    = bcs_pkg::RST_DIGIT_TICKS;
        cfg_post     = bcs_pkg::RST_POST_TICKS;
        active       = 1'b0;
        stage        = SEQ_IDLE;
        nibbles_rest = 16'h0;
        beeps_rest   = 4'h0;
        nibble_cnt   = 0;
        ticks_rest   = 16'h0;
        cur_code     = 4'h0;
        n_checked    = 0;
        n_errors     = 0;
        n_started    = 0;
        n_queued     = 0;
        n_full       = 0;
        n_invalid    = 0;
    endfunction

    function void set_reg(logic [bcs_pkg::CFG_IDX_W-1:0] index, logic [15:0] value);
        case (index)
            bcs_pkg::CFG_TONE_HZ:     cfg_tone  = value;
            bcs_pkg::CFG_BEEP_TICKS:  cfg_beep  = value;
            bcs_pkg::CFG_GAP_TICKS:   cfg_gap   = value;
            bcs_pkg::CFG_DIGIT_TICKS: cfg_digit = value;
            bcs_pkg::CFG_POST_TICKS:  cfg_post  = value;
            default: ;
        endcase
    endfunction

    function logic [15:0] code_pattern(logic [3:0] code);
        case (code)
            4'd1:    return 16'h1512;
            4'd2:    return 16'h1514;
            4'd3:    return 16'h1521;
            4'd4:    return 16'h1522;
            4'd5:    return 16'h1523;
            4'd6:    return 16'h1524;
            4'd7:    return 16'h1525;
            4'd8:    return 16'h1542;
            4'd9:    return 16'h1544;
            default: return 16'h0000;
        endcase
    endfunction

    // next nonzero nibble, MSB first; zero nibbles are skipped
    function logic [3:0] take_digit();
        logic [3:0] nib;
        int         sh;
        while (nibble_cnt > 0)
        begin
            sh = (nibble_cnt - 1) * 4;
            nib = nibbles_rest[sh +: 4];
            nibbles_rest[sh +: 4] = 4'h0;
            nibble_cnt--;
            if (nib != 4'h0)
                return nib;
        end
        return 4'h0;
    endfunction

    function void load_digit();
        logic [3:0] nib;
        nib = take_digit();
        beeps_rest = (nib != 4'h0) ? nib - 4'd1 : 4'd0;
    endfunction

    function void start_code(logic [3:0] code);
        cur_code     = code;
        nibbles_rest = code_pattern(code);
        nibble_cnt   = 4;
        load_digit();
        stage        = SEQ_TONE;
        active       = 1'b1;
        ticks_rest   = cfg_beep;
    endfunction

    function void go_quiet();
        active     = 1'b0;
        stage      = SEQ_IDLE;
        cur_code   = 4'h0;
        ticks_rest = 16'h0;
    endfunction

    function void advance_stage();
        logic [3:0] code;
        case (stage)
            SEQ_TONE:
            begin
                if (beeps_rest == 4'h0)
                begin
                    if (nibbles_rest == 16'h0)
                    begin
                        stage      = SEQ_TAIL;
                        ticks_rest = cfg_post;
                    end
                    else
                    begin
                        load_digit();
                        stage      = SEQ_DIGIT_GAP;
                        ticks_rest = cfg_digit;
                    end
                end
                else
                begin
                    beeps_rest = beeps_rest - 4'd1;
                    stage      = SEQ_BEEP_GAP;
                    ticks_rest = cfg_gap;
                end
            end
            SEQ_BEEP_GAP, SEQ_DIGIT_GAP:
            begin
                stage      = SEQ_TONE;
                ticks_rest = cfg_beep;
            end
            SEQ_TAIL:
            begin
                if (waitq.size() > 0)
                begin
                    code = waitq[0];
                    waitq.delete(0);
                    start_code(code);
                end
                else
                    go_quiet();
            end
            default: go_quiet();
        endcase
    endfunction

    function void note_input(logic cmd, logic [3:0] code);
        bcs_pkg::status_t st;
        tone_word_t       w;
        int               pos;
        st = bcs_pkg::ST_TICK;
        if (cmd == bcs_pkg::CMD_TICK)
        begin
            if (active)
            begin
                if (ticks_rest > 16'd1)
                    ticks_rest = ticks_rest - 16'd1;
                else
                    advance_stage();
            end
        end
        else if (code < bcs_pkg::IDX_MIN || code > bcs_pkg::IDX_MAX)
        begin
            st = bcs_pkg::ST_INVALID;
            n_invalid++;
        end
        else if (active)
        begin
            if (waitq.size() >= bcs_pkg::PENDING_DEPTH_DEF)
            begin
                st = bcs_pkg::ST_FULL;
                n_full++;
            end
            else
            begin
                // larger index first, new word goes behind equal ones
                pos = waitq.size();
                while (pos > 0 && waitq[pos-1] < code)
                    pos--;
                waitq.insert(pos, code);
                st = bcs_pkg::ST_QUEUED;
                n_queued++;
            end
        end
        else
        begin
            start_code(code);
            st = bcs_pkg::ST_STARTED;
            n_started++;
        end
        w.tone_on = active && (stage == SEQ_TONE);
        w.freq    = cfg_tone;
        w.busy    = active;
        w.status  = st;
        w.playing = active ? cur_code : 4'h0;
        expected_words.insert(expected_words.size(), w);
    endfunction

    function void field_check(string field, logic [15:0] want_v, logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            n_errors++;
            if (n_errors <= 40)
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, field, want_v, got_v);
        end
    endfunction

    function void check_result(tone_word_t got);
        tone_word_t want;
        if (expected_words.size() == 0)
        begin
            n_errors++;
            if (n_errors <= 40)
                $display("%0t: unexpected rsp word, expected none, got status %0d",
                         $time, got.status);
            return;
        end
        want = expected_words[0];
        expected_words.delete(0);
        n_checked++;
        field_check("tone_on", 16'(want.tone_on), 16'(got.tone_on));
        field_check("tone_freq", want.freq, got.freq);
        field_check("busy_res", 16'(want.busy), 16'(got.busy));
        field_check("status", 16'(want.status), 16'(got.status));
        field_check("playing_index", 16'(want.playing), 16'(got.playing));
    endfunction
endclass

module beep_code_sequencer_test;

    logic clk = 1'b0;
    logic rst_n;

    bcs_req_if req();
    bcs_rsp_if rsp();
    bcs_cfg_if cfg();

    beep_code_sequencer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    tone_scoreboard sb;
    int             burst_left;
    tone_word_t     seen;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid === 1'b1 && rsp.ready)
        begin
            seen.tone_on = rsp.tone_on;
            seen.freq    = rsp.tone_freq;
            seen.busy    = rsp.busy_res;
            seen.status  = bcs_pkg::status_t'(rsp.status);
            seen.playing = rsp.playing_index;
            sb.check_result(seen);
        end
    end

    // receiver: stretches of full rate, light and heavy stalls
    initial
    begin
        int mode;
        int left;
        rsp.ready = 1'b0;
        left = 0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(3, 0);
                left = $urandom_range(64, 8);
            end
            left--;
            case (mode)
                0:       rsp.ready <= 1'b1;
                1:       rsp.ready <= ($urandom_range(3, 0) != 0);
                2:       rsp.ready <= ($urandom_range(2, 0) == 0);
                default: rsp.ready <= (left % 3 != 0);
            endcase
        end
    end

    initial
    begin
        #40000000;
        $display("beep_code_sequencer_test: done, errors");
        $finish;
    end

    task automatic send_word(logic cmd, logic [3:0] code);
        int g;
        req.valid      <= 1'b1;
        req.cmd        <= cmd;
        req.code_index <= code;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_input(cmd, code);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(24, 1);
            if ($urandom_range(3, 0) != 0)
            begin
                g = $urandom_range(6, 1);
                req.valid <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    endtask

    task automatic send_random(int count, int req_pct);
        logic       cmd;
        logic [3:0] code;
        repeat (count)
        begin
            if ($urandom_range(99, 0) < req_pct)
            begin
                cmd = bcs_pkg::CMD_REQ;
                if ($urandom_range(9, 0) == 0)
                begin
                    code = 4'($urandom_range(6, 0));
                    if (code != 4'd0)
                        code = code + 4'd9;
                end
                else
                    code = 4'($urandom_range(9, 1));
            end
            else
            begin
                cmd  = bcs_pkg::CMD_TICK;
                code = 4'($urandom_range(15, 0));
            end
            send_word(cmd, code);
        end
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        req.valid <= 1'b0;
        while (sb.expected_words.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    // tick until the pattern and every queued request have played out
    task automatic settle();
        while (sb.active)
            send_word(bcs_pkg::CMD_TICK, 4'($urandom_range(15, 0)));
        wait_drained();
    endtask

    task automatic configure(logic [15:0] tone, logic [15:0] beep, logic [15:0] gap,
                             logic [15:0] digit, logic [15:0] post);
        logic [15:0]                   vals[5];
        logic [bcs_pkg::CFG_IDX_W-1:0] regs[5];
        int                            i;
        vals = '{tone, beep, gap, digit, post};
        regs = '{bcs_pkg::CFG_TONE_HZ, bcs_pkg::CFG_BEEP_TICKS, bcs_pkg::CFG_GAP_TICKS,
                 bcs_pkg::CFG_DIGIT_TICKS, bcs_pkg::CFG_POST_TICKS};
        for (i = 0; i < 5; i++)
        begin
            cfg.valid <= 1'b1;
            cfg.index <= regs[i];
            cfg.data  <= vals[i];
            @(posedge clk);
            while (!cfg.ready)
                @(posedge clk);
            sb.set_reg(regs[i], vals[i]);
        end
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        int rates[5];
        int lims[5];
        int ph;
        int limit;
        sb = new();
        burst_left = 1;
        rates = '{4, 6, 9, 3, 8};
        lims = '{1, 2, 0, 3, 1};
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.cmd = bcs_pkg::CMD_TICK;
        req.code_index = 4'd0;
        cfg.valid = 1'b0;
        cfg.index = bcs_pkg::CFG_TONE_HZ;
        cfg.data = 16'h0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset delays: idle tick, invalid indexes, first beep at default length
        send_word(bcs_pkg::CMD_TICK, 4'd7);
        send_word(bcs_pkg::CMD_REQ, 4'd0);
        send_word(bcs_pkg::CMD_REQ, 4'd15);
        send_word(bcs_pkg::CMD_REQ, 4'd10);
        send_word(bcs_pkg::CMD_REQ, bcs_pkg::IDX_MIN);
        repeat (3) send_word(bcs_pkg::CMD_TICK, 4'd0);
        send_word(bcs_pkg::CMD_REQ, 4'd0);
        wait_drained();
        configure(16'h0000, 16'h0, 16'h0, 16'h0, 16'h0);
        settle();

        // one-tick phases, queue filled past its depth with duplicates
        configure(16'h0000, 16'h0, 16'h0, 16'h0, 16'h0);
        send_word(bcs_pkg::CMD_REQ, bcs_pkg::IDX_MAX);
        send_word(bcs_pkg::CMD_REQ, bcs_pkg::IDX_MIN);
        send_word(bcs_pkg::CMD_REQ, bcs_pkg::IDX_MAX);
        send_word(bcs_pkg::CMD_REQ, 4'd5);
        send_word(bcs_pkg::CMD_REQ, 4'd5);
        send_word(bcs_pkg::CMD_REQ, 4'd2);
        send_word(bcs_pkg::CMD_REQ, 4'd3);
        send_word(bcs_pkg::CMD_REQ, 4'd4);
        send_word(bcs_pkg::CMD_REQ, 4'd8);
        send_word(bcs_pkg::CMD_REQ, 4'd7);
        send_word(bcs_pkg::CMD_REQ, 4'd12);
        send_word(bcs_pkg::CMD_TICK, 4'd15);
        settle();

        for (ph = 0; ph < 5; ph++)
        begin
            limit = lims[ph];
            configure(16'($urandom_range(65535, 0)), 16'($urandom_range(limit, 0)),
                      16'($urandom_range(limit, 0)), 16'($urandom_range(limit, 0)),
                      16'($urandom_range(limit, 0)));
            send_random(70, rates[ph]);
            settle();
        end

        configure(16'hFFFF, 16'h0, 16'h1, 16'h0, 16'h2);
        send_word(bcs_pkg::CMD_REQ, bcs_pkg::IDX_MAX);
        settle();

        if (sb.expected_words.size() != 0)
        begin
            $display("%0t: %0d rsp words never arrived", $time, sb.expected_words.size());
            sb.n_errors += sb.expected_words.size();
        end
        $display("%0d rsp words checked across default, directed and random register settings",
                 sb.n_checked);
        $display("patterns started %0d, queued %0d, dropped on full queue %0d, invalid %0d",
                 sb.n_started, sb.n_queued, sb.n_full, sb.n_invalid);
        if (sb.n_errors == 0)
            $display("beep_code_sequencer_test: done, clean");
        else
            $display("beep_code_sequencer_test: done, errors");
        $finish;
    end

endmodule
